@@ hw/rtl/gamepad_serial_responder_core_assert.svh @@
// Assertion macros shared by the game-pad responder RTL.
// Stand-alone header; no other file is needed.
`ifndef GAMEPAD_SERIAL_RESPONDER_CORE_ASSERT_SVH
`define GAMEPAD_SERIAL_RESPONDER_CORE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define GSR_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsr check failed: same-cycle implication");

// Next-cycle implication, quiet during reset.
`define GSR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsr check failed: next-cycle implication");

`endif

@@ hw/rtl/gsr_pkg.sv @@
// Package for the game-pad serial responder: codes, types and byte tables.
// No dependencies.
`default_nettype none

package gsr_pkg;

    localparam int NUM_PORTS_DEF = 2;
    localparam int FRAME_BYTES   = 8;
    localparam int SHORT_FRAME   = FRAME_BYTES / 2;
    localparam int IDX_W         = $clog2(FRAME_BYTES + 1);

    // Request kinds
    localparam logic [1:0] KIND_INIT     = 2'd0;
    localparam logic [1:0] KIND_START    = 2'd1;
    localparam logic [1:0] KIND_EXCHANGE = 2'd2;

    // Console commands (first byte of a frame)
    localparam logic [7:0] CMD_READ     = 8'h42;
    localparam logic [7:0] CMD_CONFIG   = 8'h43;
    localparam logic [7:0] CMD_SET_MODE = 8'h44;
    localparam logic [7:0] CMD_MODEL    = 8'h45;
    localparam logic [7:0] CMD_ACT      = 8'h46;
    localparam logic [7:0] CMD_COMB     = 8'h47;
    localparam logic [7:0] CMD_QMODE    = 8'h4C;
    localparam logic [7:0] CMD_MAP      = 8'h4D;

    // Response bytes and identities
    localparam logic [7:0] ID_DIGITAL    = 8'h41;
    localparam logic [7:0] ID_ANALOG     = 8'h73;
    localparam logic [7:0] RSP_CONFIG    = 8'hF3;
    localparam logic [7:0] RSP_MARKER    = 8'h5A;
    localparam logic [7:0] RSP_IDLE      = 8'hFF;
    localparam logic [7:0] TYPE_STANDARD = 8'h04;
    localparam logic [7:0] TYPE_ANALOG   = 8'h07;

    typedef enum logic [2:0] {
        SRC_PAR,
        SRC_ZERO,
        SRC_MODEL,
        SRC_ACT,
        SRC_COMB,
        SRC_QMODE,
        SRC_TOGGLE
    } frame_src_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        port;
        logic        is_analog_pad;
        logic [15:0] buttons;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  tx_byte;
    } item_t;

    // Persistent state of one controller port
    typedef struct packed {
        logic [7:0]      mode;
        logic [7:0]      ident;
        logic            cfg_active;
        logic [1:0][3:0] slot;
        logic [1:0][7:0] level;
        logic            act_alt;
        logic [7:0]      mtype;
        logic [5:0]      toggle;
    } port_state_t;

    // Write requests from the frame engine to one port bank
    typedef struct packed {
        logic       mode_we;
        logic [7:0] mode_val;
        logic       ident_we;
        logic [7:0] ident_val;
        logic       cfg_we;
        logic       cfg_val;
        logic       act_we;
        logic       act_alt;
        logic       mtype_we;
        logic [7:0] mtype_val;
        logic [1:0] level_we;
        logic [7:0] level_val;
        logic       slot_we;
        logic       slot_sel;
        logic [3:0] slot_val;
        logic [5:0] toggle_clr;
    } port_upd_t;

    function automatic logic [7:0] comb_byte(input logic [2:0] b);
        logic [7:0] v;
        case (b)
            3'd0:    v = 8'hFF;
            3'd1:    v = 8'h5A;
            3'd4:    v = 8'h02;
            3'd6:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] model_byte(input logic [2:0] b, input logic [7:0] snap);
        logic [7:0] v;
        case (b)
            3'd2:    v = 8'h01;
            3'd3:    v = 8'h02;
            3'd4:    v = snap;
            3'd5:    v = 8'h02;
            3'd6:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Actuator tail: alt 0 reads 02 00 0A, alt 1 reads 01 01 14
    function automatic logic [7:0] act_tail_byte(input logic alt, input logic [1:0] sel);
        logic [7:0] v;
        case (sel)
            2'd0:    v = alt ? 8'h01 : 8'h02;
            2'd1:    v = alt ? 8'h01 : 8'h00;
            2'd2:    v = alt ? 8'h14 : 8'h0A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Motor level class of a mapped byte position: (b - 1) / 2
    function automatic logic [1:0] map_level(input logic [2:0] b);
        logic [1:0] v;
        case (b)
            3'd3, 3'd4: v = 2'd1;
            3'd5, 3'd6: v = 2'd2;
            3'd7:       v = 2'd3;
            default:    v = 2'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gsr_request_if.sv @@
// Request channel of the game-pad responder: valid/ready plus item fields.
// No dependencies.
`default_nettype none

interface gsr_request_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        port;
    logic        is_analog_pad;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  tx_byte;

    modport source (
        output valid, kind, port, is_analog_pad, buttons,
               right_x, right_y, left_x, left_y, tx_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, port, is_analog_pad, buttons,
               right_x, right_y, left_x, left_y, tx_byte,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/gsr_response_if.sv @@
// Response channel of the game-pad responder: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface gsr_response_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       vibrate_event;
    logic [7:0] motor_small;
    logic [7:0] motor_large;

    modport source (
        output valid, rx_byte, vibrate_event, motor_small, motor_large,
        input  ready
    );
    modport sink (
        input  valid, rx_byte, vibrate_event, motor_small, motor_large,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/gamepad_serial_responder_core.sv @@
// Top level of the dual-port game-pad serial responder.
// Depends on gsr_pkg, gsr_request_if, gsr_response_if, gsr_port_bank,
// gsr_frame_engine and gamepad_serial_responder_core_assert.svh.
`default_nettype none
`include "gamepad_serial_responder_core_assert.svh"

// Controller side of a game-pad serial link serving up to two ports. Each
// request is one of: init a port (sets its ident and mode from the pad type),
// start a poll (selects the active port, rewinds the byte index and latches
// buttons and sticks), or exchange one byte (returns the pad's reply byte and
// updates the port tables). Every request yields exactly one response carrying
// the reply byte, a vibrate flag and the two motor levels of the active port
// after the request. Timing: a request is taken into an input register, its
// whole update runs through one pass of logic, and the response is then
// registered in the output register. A request may be taken every cycle while
// the response side keeps up; the per-request read-modify-write of the port
// tables completes in that one pass. A request waiting in the input register
// moves on as soon as the output register is free or being emptied. All
// tables sit in flip-flops and are set to their start values by reset at once,
// so the block is ready as soon as reset is released. The vibration enable
// register may only be written while no request is in flight.
module gamepad_serial_responder_core #(
    parameter int NUM_PORTS = gsr_pkg::NUM_PORTS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    gsr_request_if.sink     request,
    gsr_response_if.source  response,
    input  wire logic       cfg_write_en,
    input  wire logic       cfg_write_data
);

    localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // Configuration: vibration enable, set at reset
    logic vib_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vib_en_reg <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            vib_en_reg <= cfg_write_data;
        end
    end

    // Input register: hold the accepted request until the output side frees
    logic           s1_valid_reg;
    gsr_pkg::item_t s1_item_reg;
    logic           out_valid_reg;
    logic           advance;

    assign advance       = s1_valid_reg && (!out_valid_reg || response.ready);
    assign request.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            s1_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            s1_item_reg.kind          <= request.kind;
            s1_item_reg.port          <= request.port;
            s1_item_reg.is_analog_pad <= request.is_analog_pad;
            s1_item_reg.buttons       <= request.buttons;
            s1_item_reg.right_x       <= request.right_x;
            s1_item_reg.right_y       <= request.right_y;
            s1_item_reg.left_x        <= request.left_x;
            s1_item_reg.left_y        <= request.left_y;
            s1_item_reg.tx_byte       <= request.tx_byte;
        end
    end

    // Frame engine: decode the request and raise writes to one port bank
    logic [PORT_W-1:0]    active_port;
    logic [PORT_W-1:0]    next_port;
    logic [PORT_W-1:0]    upd_port;
    gsr_pkg::port_upd_t   upd;
    logic                 upd_we;
    logic [7:0]           rx_byte;
    logic                 vibrate_event;
    gsr_pkg::port_state_t act_state;

    gsr_frame_engine #(
        .NUM_PORTS (NUM_PORTS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .item          (s1_item_reg),
        .vib_en        (vib_en_reg),
        .act_state     (act_state),
        .active_port   (active_port),
        .next_port     (next_port),
        .upd_port      (upd_port),
        .upd           (upd),
        .upd_we        (upd_we),
        .rx_byte       (rx_byte),
        .vibrate_event (vibrate_event)
    );

    // One register bank per port; only the addressed bank takes the write
    gsr_pkg::port_state_t bank_state [NUM_PORTS];
    logic [1:0][7:0]      bank_level_next [NUM_PORTS];

    for (genvar g = 0; g < NUM_PORTS; g++)
    begin : g_port
        gsr_port_bank u_bank (
            .clk        (clk),
            .rst_n      (rst_n),
            .we         (upd_we && (upd_port == PORT_W'(g))),
            .upd        (upd),
            .state      (bank_state[g]),
            .level_next (bank_level_next[g])
        );
    end

    // Select the active port's tables, and the motor levels of the port
    // that is active once this request has been applied
    logic [1:0][7:0] motor_next;

    always_comb
    begin
        act_state  = bank_state[0];
        motor_next = bank_level_next[0];
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            if (active_port == PORT_W'(i))
            begin
                act_state = bank_state[i];
            end
            if (next_port == PORT_W'(i))
            begin
                motor_next = bank_level_next[i];
            end
        end
    end

    // Output register: load on advance, drop once the response is taken
    logic [7:0] rx_byte_reg;
    logic       vibrate_reg;
    logic [7:0] motor_small_reg;
    logic [7:0] motor_large_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rx_byte_reg     <= rx_byte;
            vibrate_reg     <= vibrate_event;
            motor_small_reg <= motor_next[0];
            motor_large_reg <= motor_next[1];
        end
    end

    assign response.valid         = out_valid_reg;
    assign response.rx_byte       = rx_byte_reg;
    assign response.vibrate_event = vibrate_reg;
    assign response.motor_small   = motor_small_reg;
    assign response.motor_large   = motor_large_reg;

    // A vibrate flag can only leave while vibration is enabled
    `GSR_ASSERT_IMPLY(a_event_needs_enable, clk, rst_n, response.valid && response.vibrate_event, vib_en_reg)
    // Init and start requests, and unused kinds, answer with the idle byte
    `GSR_ASSERT_NEXT(a_idle_reply, clk, rst_n, advance && (s1_item_reg.kind != gsr_pkg::KIND_EXCHANGE), response.valid && (response.rx_byte == gsr_pkg::RSP_IDLE) && !response.vibrate_event)
    // An accepted request always occupies the input register next cycle
    `GSR_ASSERT_NEXT(a_capture, clk, rst_n, request.valid && request.ready, s1_valid_reg)

endmodule

`default_nettype wire

@@ hw/rtl/gsr_port_bank.sv @@
// Register bank of one controller port: mode, ident, motors and tables.
// Depends on gsr_pkg.
`default_nettype none

module gsr_port_bank (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    we,
    input  wire gsr_pkg::port_upd_t      upd,
    output gsr_pkg::port_state_t         state,
    output logic [1:0][7:0]              level_next
);

    logic [7:0]      mode_reg;
    logic [7:0]      ident_reg;
    logic            cfg_active_reg;
    logic [1:0][3:0] slot_reg;
    logic [1:0][7:0] level_reg;
    logic            act_alt_reg;
    logic [7:0]      mtype_reg;
    logic [5:0]      toggle_reg;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            level_next[i] = (we && upd.level_we[i]) ? upd.level_val : level_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= '0;
            ident_reg      <= gsr_pkg::ID_DIGITAL;
            cfg_active_reg <= 1'b0;
            slot_reg       <= '0;
            level_reg      <= '0;
            act_alt_reg    <= 1'b0;
            mtype_reg      <= '0;
            toggle_reg     <= '1;
        end
        else if (we)
        begin
            if (upd.mode_we)
            begin
                mode_reg <= upd.mode_val;
            end
            if (upd.ident_we)
            begin
                ident_reg <= upd.ident_val;
            end
            if (upd.cfg_we)
            begin
                cfg_active_reg <= upd.cfg_val;
            end
            if (upd.act_we)
            begin
                act_alt_reg <= upd.act_alt;
            end
            if (upd.mtype_we)
            begin
                mtype_reg <= upd.mtype_val;
            end
            if (upd.slot_we)
            begin
                slot_reg[upd.slot_sel] <= upd.slot_val;
            end
            level_reg  <= level_next;
            toggle_reg <= toggle_reg & ~upd.toggle_clr;
        end
    end

    always_comb
    begin
        state.mode       = mode_reg;
        state.ident      = ident_reg;
        state.cfg_active = cfg_active_reg;
        state.slot       = slot_reg;
        state.level      = level_reg;
        state.act_alt    = act_alt_reg;
        state.mtype      = mtype_reg;
        state.toggle     = toggle_reg;
    end

endmodule

`default_nettype wire

@@ hw/rtl/gsr_frame_engine.sv @@
// Frame sequencer: byte index, command decode, latched pad data, response byte
// and write requests to the port banks. Depends on gsr_pkg.
`default_nettype none

module gsr_frame_engine #(
    parameter int NUM_PORTS = gsr_pkg::NUM_PORTS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    fire,
    input  wire gsr_pkg::item_t          item,
    input  wire logic                    vib_en,
    input  wire gsr_pkg::port_state_t    act_state,
    output logic [((NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1)-1:0] active_port,
    output logic [((NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1)-1:0] next_port,
    output logic [((NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1)-1:0] upd_port,
    output gsr_pkg::port_upd_t           upd,
    output logic                         upd_we,
    output logic [7:0]                   rx_byte,
    output logic                         vibrate_event
);

    localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int IDX_W  = gsr_pkg::IDX_W;

    logic [PORT_W-1:0]   active_port_reg, active_port_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [7:0]          cmd_reg, cmd_next;
    logic                frame_long_reg, frame_long_next;
    gsr_pkg::frame_src_t src_reg, src_next;
    logic [7:0]          snap_reg, snap_next;
    logic [15:0]         buttons_reg, buttons_next;
    logic [7:0]          rx_reg, rx_next;
    logic [7:0]          ry_reg, ry_next;
    logic [7:0]          lx_reg, lx_next;
    logic [7:0]          ly_reg, ly_next;
    logic                analog_reg, analog_next;

    always_comb
    begin
        logic [PORT_W-1:0] port_sel;
        logic [7:0]        cmd_new;
        logic [2:0]        b;
        logic [2:0]        tidx;
        logic [IDX_W-1:0]  frame_len;
        logic [1:0]        lvl;
        logic              hit;

        port_sel  = (int'(item.port) < NUM_PORTS) ? PORT_W'(item.port) : '0;
        cmd_new   = item.is_analog_pad ? item.tx_byte : gsr_pkg::CMD_READ;
        cmd_new   = analog_reg ? item.tx_byte : gsr_pkg::CMD_READ;
        b         = idx_reg[2:0];
        tidx      = b - 3'd2;
        frame_len = frame_long_reg ? IDX_W'(gsr_pkg::FRAME_BYTES)
                                   : IDX_W'(gsr_pkg::SHORT_FRAME);
        lvl       = gsr_pkg::map_level(b);
        hit       = (act_state.slot[0] == {1'b0, b}) || (act_state.slot[1] == {1'b0, b});

        active_port_next = active_port_reg;
        idx_next         = idx_reg;
        cmd_next         = cmd_reg;
        frame_long_next  = frame_long_reg;
        src_next         = src_reg;
        snap_next        = snap_reg;
        buttons_next     = buttons_reg;
        rx_next          = rx_reg;
        ry_next          = ry_reg;
        lx_next          = lx_reg;
        ly_next          = ly_reg;
        analog_next      = analog_reg;

        upd           = '0;
        upd_port      = active_port_reg;
        rx_byte       = gsr_pkg::RSP_IDLE;
        vibrate_event = 1'b0;

        case (item.kind)
            gsr_pkg::KIND_INIT:
            begin
                upd_port      = port_sel;
                upd.mode_we   = 1'b1;
                upd.mode_val  = {7'd0, item.is_analog_pad};
                upd.ident_we  = 1'b1;
                upd.ident_val = item.is_analog_pad ? gsr_pkg::ID_ANALOG : gsr_pkg::ID_DIGITAL;
            end
            gsr_pkg::KIND_START:
            begin
                active_port_next = port_sel;
                idx_next         = '0;
                buttons_next     = item.buttons;
                rx_next          = item.right_x;
                ry_next          = item.right_y;
                lx_next          = item.left_x;
                ly_next          = item.left_y;
                analog_next      = item.is_analog_pad;
            end
            gsr_pkg::KIND_EXCHANGE:
            begin
                if (idx_reg == '0)
                begin
                    // Open a frame: the command byte picks the source of the reply
                    cmd_next        = cmd_new;
                    idx_next        = IDX_W'(1);
                    frame_long_next = 1'b1;
                    rx_byte         = gsr_pkg::RSP_CONFIG;
                    src_next        = gsr_pkg::SRC_PAR;
                    case (cmd_new)
                        gsr_pkg::CMD_SET_MODE: src_next = gsr_pkg::SRC_ZERO;
                        gsr_pkg::CMD_MODEL:
                        begin
                            src_next  = gsr_pkg::SRC_MODEL;
                            snap_next = act_state.mode;
                        end
                        gsr_pkg::CMD_ACT:      src_next = gsr_pkg::SRC_ACT;
                        gsr_pkg::CMD_COMB:     src_next = gsr_pkg::SRC_COMB;
                        gsr_pkg::CMD_QMODE:    src_next = gsr_pkg::SRC_QMODE;
                        gsr_pkg::CMD_MAP:      src_next = gsr_pkg::SRC_TOGGLE;
                        default:               src_next = gsr_pkg::SRC_PAR;
                    endcase
                    if (cmd_new == gsr_pkg::CMD_CONFIG && act_state.cfg_active)
                    begin
                        src_next = gsr_pkg::SRC_ZERO;
                    end
                    if (src_next == gsr_pkg::SRC_PAR)
                    begin
                        frame_long_next = (act_state.mode == 8'd1);
                        rx_byte         = act_state.ident;
                    end
                end
                else if (idx_reg < frame_len)
                begin
                    idx_next = idx_reg + IDX_W'(1);

                    if (b == 3'd2)
                    begin
                        case (cmd_reg)
                            gsr_pkg::CMD_CONFIG:
                            begin
                                upd.cfg_we  = 1'b1;
                                upd.cfg_val = |item.tx_byte;
                            end
                            gsr_pkg::CMD_SET_MODE:
                            begin
                                upd.mode_we   = 1'b1;
                                upd.mode_val  = item.tx_byte;
                                upd.ident_we  = 1'b1;
                                upd.ident_val = (|item.tx_byte) ? gsr_pkg::ID_ANALOG
                                                                : gsr_pkg::ID_DIGITAL;
                            end
                            gsr_pkg::CMD_ACT:
                            begin
                                upd.act_we  = (item.tx_byte < 8'd2);
                                upd.act_alt = item.tx_byte[0];
                            end
                            gsr_pkg::CMD_QMODE:
                            begin
                                upd.mtype_we  = (item.tx_byte < 8'd2);
                                upd.mtype_val = item.tx_byte[0] ? gsr_pkg::TYPE_ANALOG
                                                                : gsr_pkg::TYPE_STANDARD;
                            end
                            default: ;
                        endcase
                    end

                    if (analog_reg && b >= 3'd2)
                    begin
                        case (cmd_reg)
                            gsr_pkg::CMD_READ:
                            begin
                                for (int i = 0; i < 2; i++)
                                begin
                                    upd.level_we[i] = (act_state.slot[i] == {1'b0, b})
                                                   && (act_state.level[i] != item.tx_byte);
                                end
                                upd.level_val = item.tx_byte;
                                vibrate_event = (|upd.level_we) && vib_en;
                            end
                            gsr_pkg::CMD_MAP:
                            begin
                                upd.toggle_clr[tidx] = hit;
                                if (item.tx_byte < 8'd2)
                                begin
                                    upd.slot_we  = 1'b1;
                                    upd.slot_sel = item.tx_byte[0];
                                    upd.slot_val = {1'b0, b};
                                    if (act_state.ident[3:0] < {2'b00, lvl})
                                    begin
                                        upd.ident_we  = 1'b1;
                                        upd.ident_val = {act_state.ident[7:4], 2'b00, lvl};
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end

                    if (b == 3'd1)
                    begin
                        rx_byte = gsr_pkg::RSP_MARKER;
                    end
                    else
                    begin
                        case (src_reg)
                            gsr_pkg::SRC_PAR:
                            begin
                                case (b)
                                    3'd2:    rx_byte = buttons_reg[7:0];
                                    3'd3:    rx_byte = buttons_reg[15:8];
                                    3'd4:    rx_byte = rx_reg;
                                    3'd5:    rx_byte = ry_reg;
                                    3'd6:    rx_byte = lx_reg;
                                    default: rx_byte = ly_reg;
                                endcase
                            end
                            gsr_pkg::SRC_MODEL:
                                rx_byte = gsr_pkg::model_byte(b, snap_reg);
                            gsr_pkg::SRC_ACT:
                            begin
                                if (b == 3'd4)
                                begin
                                    rx_byte = 8'h01;
                                end
                                else if (b >= 3'd5)
                                begin
                                    rx_byte = gsr_pkg::act_tail_byte(act_state.act_alt,
                                                                     2'(b - 3'd5));
                                end
                                else
                                begin
                                    rx_byte = 8'h00;
                                end
                            end
                            gsr_pkg::SRC_COMB:
                                rx_byte = gsr_pkg::comb_byte(b);
                            gsr_pkg::SRC_QMODE:
                                rx_byte = (b == 3'd5) ? act_state.mtype : 8'h00;
                            gsr_pkg::SRC_TOGGLE:
                                rx_byte = (act_state.toggle[tidx] && !upd.toggle_clr[tidx])
                                        ? 8'hFF : 8'h00;
                            default:
                                rx_byte = 8'h00;
                        endcase
                    end
                end
            end
            default: ;
        endcase

        upd_we = fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_port_reg <= '0;
            idx_reg         <= '0;
            cmd_reg         <= '0;
            frame_long_reg  <= 1'b0;
            src_reg         <= gsr_pkg::SRC_PAR;
            snap_reg        <= '0;
            buttons_reg     <= '0;
            rx_reg          <= '0;
            ry_reg          <= '0;
            lx_reg          <= '0;
            ly_reg          <= '0;
            analog_reg      <= 1'b0;
        end
        else if (fire)
        begin
            active_port_reg <= active_port_next;
            idx_reg         <= idx_next;
            cmd_reg         <= cmd_next;
            frame_long_reg  <= frame_long_next;
            src_reg         <= src_next;
            snap_reg        <= snap_next;
            buttons_reg     <= buttons_next;
            rx_reg          <= rx_next;
            ry_reg          <= ry_next;
            lx_reg          <= lx_next;
            ly_reg          <= ly_next;
            analog_reg      <= analog_next;
        end
    end

    assign active_port = active_port_reg;
    assign next_port   = active_port_next;

endmodule

`default_nettype wire
